FILE: hw/rtl/sscc_pkg.sv
package sscc_pkg;

  localparam int unsigned ScratchpadBytes = 9;
  localparam int unsigned CountW          = 4;
  localparam int unsigned TempW           = 16;
  localparam int unsigned ByteW           = 8;

  localparam logic [ByteW-1:0]  CrcPolyRefl = 8'h8C;
  localparam logic [CountW-1:0] CheckIdx    = CountW'(ScratchpadBytes - 1);
  localparam logic [CountW-1:0] DoneIdx     = CountW'(ScratchpadBytes);

  typedef struct packed {
    logic                    valid;
    logic signed [TempW-1:0] temperature;
    logic                    crc_ok;
    logic [ByteW-1:0]        computed_crc;
    logic [ByteW-1:0]        received_crc;
  } sscc_res_t;

  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] d;
    logic             mix;
    c = crc;
    d = data;
    for (int b = 0; b < ByteW; b++) begin
      mix = c[0] ^ d[0];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CrcPolyRefl;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/sscc_frame.sv
module sscc_frame
  import sscc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] data_i,
  input  logic             start_i,
  output sscc_res_t        res_o
);

  logic [ByteW-1:0]        crc_q, crc_d;
  logic [CountW-1:0]       cnt_q, cnt_d;
  logic [ByteW-1:0]        lo_q, lo_d;
  logic [ByteW-1:0]        hi_q, hi_d;
  logic signed [TempW-1:0] temp_q, temp_d;

  logic [CountW-1:0] idx;
  logic [ByteW-1:0]  crc_base;

  always_comb begin
    idx      = start_i ? '0 : cnt_q;
    crc_base = start_i ? '0 : crc_q;
    crc_d    = crc_q;
    cnt_d    = cnt_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    temp_d   = temp_q;

    res_o.valid        = 1'b0;
    res_o.crc_ok       = (crc_base == data_i);
    res_o.computed_crc = crc_base;
    res_o.received_crc = data_i;

    if (idx < CheckIdx) begin
      crc_d = crc8_byte(crc_base, data_i);
      cnt_d = idx + 1'b1;
      if (idx == '0) begin
        lo_d = data_i;
      end
      if (idx == CountW'(1)) begin
        hi_d = data_i;
      end
    end else if (idx == CheckIdx) begin
      crc_d       = crc_base;
      cnt_d       = DoneIdx;
      res_o.valid = 1'b1;
      if (res_o.crc_ok) begin
        temp_d = {hi_q, lo_q};
      end
    end
    res_o.temperature = temp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      cnt_q  <= '0;
      lo_q   <= '0;
      hi_q   <= '0;
      temp_q <= '0;
    end else if (step_i) begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      temp_q <= temp_d;
    end
  end

  // count never runs past the finished mark
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= DoneIdx)
    else $error("byte count out of range");

endmodule

FILE: hw/rtl/sensor_scratchpad_crc_check_unit.sv
// path: an accepted input beat is registered in the input stage, and its result beat in the output register
// throughput: one byte per cycle, one result beat per scratchpad at the check byte
// a stalled output holds only beats that produce a result; other bytes keep flowing
// reset: asynchronous active low, clears crc, byte count, temperature bytes,
// held temperature and both valid flags
module sensor_scratchpad_crc_check_unit
  import sscc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // temperature, computed_crc, received_crc
  output logic        m_axis_tuser    // crc_ok
);

  logic             in_vld_q;
  logic [ByteW-1:0] in_data_q;
  logic             in_start_q;
  logic             in_adv;

  logic             out_vld_q;
  sscc_res_t        out_q;
  sscc_res_t        res;

  sscc_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_adv),
    .data_i  (in_data_q),
    .start_i (in_start_q),
    .res_o   (res)
  );

  assign in_adv        = in_vld_q && (!res.valid || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_adv && res.valid) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.crc_ok;
  assign m_axis_tdata  = {out_q.received_crc, out_q.computed_crc, out_q.temperature};

  assert property (@(posedge clk_i) disable iff (!rst_ni) !s_axis_tready |-> in_vld_q)
    else $error("input stalled while input stage empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[23:16] == m_axis_tdata[31:24])))
    else $error("crc_ok disagrees with crc fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && res.valid && m_axis_tvalid && !m_axis_tready) |-> !in_adv)
    else $error("result beat would overwrite a pending output beat");

endmodule
